// ===== rtl/core/pwbi_pkg.sv =====
// Shared types and constants for the particle wall bounce integrator.
package pwbi_pkg;

  localparam int SW = 80;
  localparam int DIV_NUM_BITS = 48;
  localparam int DIV_LAT = DIV_NUM_BITS + 2;
  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_RESTITUTION      = 3'd0,
    REG_DRAG_COEFFICIENT = 3'd1,
    REG_GRAVITY_Y        = 3'd2,
    REG_WALL_HALF_WIDTH  = 3'd3,
    REG_WALL_HALF_HEIGHT = 3'd4,
    REG_TIME_STEP        = 3'd5
  } cfg_reg_t;

  // original word, returned as is for fixed or massless items
  typedef struct packed {
    logic [31:0] p_x;
    logic [31:0] p_y;
    logic [31:0] v_x;
    logic [31:0] v_y;
    logic        bypass;
    logic        err;
  } keep_t;

endpackage

// ===== rtl/core/pwbi_div.sv =====
// Pipelined restoring divider: (num * 2^16) / den, truncated toward zero.
module pwbi_div import pwbi_pkg::*; (
  input  logic                        clk,
  input  logic signed [31:0]          num,
  input  logic        [30:0]          den,
  output logic signed [DIV_NUM_BITS:0] quo
);

  logic [DIV_NUM_BITS-1:0] nq  [DIV_NUM_BITS+1];
  logic [30:0]             rem [DIV_NUM_BITS+1];
  logic [30:0]             dv  [DIV_NUM_BITS+1];
  logic                    neg [DIV_NUM_BITS+1];
  logic [31:0]             mag;

  assign mag = num[31] ? (~num + 32'd1) : num;

  always_ff @(posedge clk) begin
    nq[0]  <= {mag, 16'd0};
    rem[0] <= '0;
    dv[0]  <= den;
    neg[0] <= num[31];
  end

  for (genvar i = 0; i < DIV_NUM_BITS; i++) begin : g_step
    logic [31:0] trial;
    logic        ge;
    always_comb begin
      trial = {rem[i], nq[i][DIV_NUM_BITS-1]};
      ge    = trial >= {1'b0, dv[i]};
    end
    always_ff @(posedge clk) begin
      rem[i+1] <= ge ? 31'(trial - {1'b0, dv[i]}) : trial[30:0];
      nq[i+1]  <= {nq[i][DIV_NUM_BITS-2:0], ge};
      dv[i+1]  <= dv[i];
      neg[i+1] <= neg[i];
    end
  end

  always_ff @(posedge clk) begin
    if (neg[DIV_NUM_BITS]) begin
      quo <= -$signed({1'b0, nq[DIV_NUM_BITS]});
    end else begin
      quo <= $signed({1'b0, nq[DIV_NUM_BITS]});
    end
  end

endmodule

// ===== rtl/core/particle_wall_bounce_integrator.sv =====
// Top level: wall clamp, drag, gravity and step integration of one point mass per word.
// Takes one word every cycle (busy stays low) and returns each result with done high;
// results cannot be held off. Most of the latency is the two divide pipelines for
// acceleration = force / mass, one per axis.
// Configuration may be written only when no word is in flight.
module particle_wall_bounce_integrator import pwbi_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [31:0]               cfg_data,
  input  logic signed [31:0]        pos_x,
  input  logic signed [31:0]        pos_y,
  input  logic signed [31:0]        vel_x,
  input  logic signed [31:0]        vel_y,
  input  logic signed [31:0]        force_x,
  input  logic signed [31:0]        force_y,
  input  logic [30:0]               radius,
  input  logic [30:0]               mass,
  input  logic                      is_fixed,
  input  logic                      is_collidable,
  output logic                      done,
  output logic signed [31:0]        new_pos_x,
  output logic signed [31:0]        new_pos_y,
  output logic signed [31:0]        new_vel_x,
  output logic signed [31:0]        new_vel_y,
  output logic                      mass_error,
  output logic                      saturated
);

  localparam int SAT_BITS = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam logic signed [SW-1:0] ONE_S  = 1;
  localparam logic signed [SW-1:0] SAT_HI = (ONE_S <<< (SAT_BITS - 1)) - ONE_S;
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - ONE_S;

  function automatic logic signed [31:0] sat_val(input logic signed [SW-1:0] x);
    if (x > SAT_HI) return SAT_HI[31:0];
    if (x < SAT_LO) return SAT_LO[31:0];
    return x[31:0];
  endfunction

  function automatic logic sat_ovf(input logic signed [SW-1:0] x);
    return (x > SAT_HI) || (x < SAT_LO);
  endfunction

  // round half up, then arithmetic shift
  function automatic logic signed [SW-1:0] rnd_shr(input logic signed [SW-1:0] x,
                                                   input int n);
    return (x + (ONE_S <<< (n - 1))) >>> n;
  endfunction

  // configuration
  logic [16:0]        restitution;
  logic [15:0]        drag_coefficient;
  logic signed [31:0] gravity_y;
  logic [30:0]        wall_half_width;
  logic [30:0]        wall_half_height;
  logic [24:0]        time_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution      <= 17'd65536;
      drag_coefficient <= 16'd6554;
      gravity_y        <= -32'sd642908;
      wall_half_width  <= 31'd7824998;
      wall_half_height <= 31'd5203558;
      time_step        <= 25'd17476;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RESTITUTION:      restitution      <= cfg_data[16:0];
        REG_DRAG_COEFFICIENT: drag_coefficient <= cfg_data[15:0];
        REG_GRAVITY_Y:        gravity_y        <= cfg_data;
        REG_WALL_HALF_WIDTH:  wall_half_width  <= cfg_data[30:0];
        REG_WALL_HALF_HEIGHT: wall_half_height <= cfg_data[30:0];
        REG_TIME_STEP:        time_step        <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic               accept;
  logic signed [31:0] in_p [2];
  logic signed [31:0] in_v [2];
  logic signed [31:0] in_f [2];
  logic [30:0]        half [2];
  logic signed [32:0] wlo  [2];
  logic signed [32:0] whi  [2];
  logic signed [25:0] dt_s;

  always_comb begin
    accept  = start && !busy;
    in_p[0] = pos_x;
    in_p[1] = pos_y;
    in_v[0] = vel_x;
    in_v[1] = vel_y;
    in_f[0] = force_x;
    in_f[1] = force_y;
    half[0] = wall_half_width;
    half[1] = wall_half_height;
    dt_s    = $signed({1'b0, time_step});
    for (int i = 0; i < 2; i++) begin
      wlo[i] = $signed({2'b00, radius}) - $signed({2'b00, half[i]});
      whi[i] = $signed({2'b00, half[i]}) - $signed({2'b00, radius});
    end
  end

  // stage 1: wall compares, first products
  logic               s1_valid;
  keep_t              s1_keep;
  logic               s1_coll;
  logic               s1_lo_hit [2];
  logic               s1_hi_hit [2];
  logic signed [32:0] s1_lo [2];
  logic signed [32:0] s1_hi [2];
  logic signed [49:0] s1_bp [2];
  logic signed [31:0] s1_p [2];
  logic signed [31:0] s1_v [2];
  logic signed [31:0] s1_f [2];
  logic [61:0]        s1_rr;
  logic signed [62:0] s1_gm;
  logic [30:0]        s1_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_keep.p_x    <= pos_x;
    s1_keep.p_y    <= pos_y;
    s1_keep.v_x    <= vel_x;
    s1_keep.v_y    <= vel_y;
    s1_keep.bypass <= is_fixed || (mass == 31'd0);
    s1_keep.err    <= !is_fixed && (mass == 31'd0);
    s1_coll        <= is_collidable;
    s1_rr          <= 62'(radius) * 62'(radius);
    s1_gm          <= 63'(gravity_y) * 63'($signed({1'b0, mass}));
    s1_m           <= mass;
    for (int i = 0; i < 2; i++) begin
      s1_lo[i]     <= wlo[i];
      s1_hi[i]     <= whi[i];
      s1_lo_hit[i] <= 33'(in_p[i]) < wlo[i];
      s1_hi_hit[i] <= 33'(in_p[i]) > whi[i];
      s1_bp[i]     <= 50'(in_v[i]) * 50'($signed({1'b0, restitution}));
      s1_p[i]      <= in_p[i];
      s1_v[i]      <= in_v[i];
      s1_f[i]      <= in_f[i];
    end
  end

  // stage 2: apply clamp and bounce
  logic signed [31:0] s2_p_next [2];
  logic signed [31:0] s2_v_next [2];
  logic               s2_flag_next;

  always_comb begin
    s2_flag_next = 1'b0;
    for (int i = 0; i < 2; i++) begin
      s2_p_next[i] = s1_p[i];
      s2_v_next[i] = s1_v[i];
      if (s1_coll && s1_lo_hit[i]) begin
        s2_p_next[i] = sat_val(SW'(s1_lo[i]));
        s2_flag_next = s2_flag_next | sat_ovf(SW'(s1_lo[i]));
      end else if (s1_coll && s1_hi_hit[i]) begin
        s2_p_next[i] = sat_val(SW'(s1_hi[i]));
        s2_flag_next = s2_flag_next | sat_ovf(SW'(s1_hi[i]));
      end
      if (s1_coll && (s1_lo_hit[i] || s1_hi_hit[i])) begin
        s2_v_next[i] = sat_val(rnd_shr(-SW'(s1_bp[i]), 16));
        s2_flag_next = s2_flag_next | sat_ovf(rnd_shr(-SW'(s1_bp[i]), 16));
      end
    end
  end

  logic               s2_valid;
  keep_t              s2_keep;
  logic               s2_flag;
  logic signed [31:0] s2_p [2];
  logic signed [31:0] s2_v [2];
  logic signed [31:0] s2_f [2];
  logic [45:0]        s2_r2;
  logic signed [46:0] s2_g;
  logic [30:0]        s2_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_keep <= s1_keep;
    s2_flag <= s2_flag_next;
    s2_r2   <= 46'((s1_rr + 62'd32768) >> 16);
    s2_g    <= 47'(rnd_shr(SW'(s1_gm), 16));
    s2_m    <= s1_m;
    for (int i = 0; i < 2; i++) begin
      s2_p[i] <= s2_p_next[i];
      s2_v[i] <= s2_v_next[i];
      s2_f[i] <= s1_f[i];
    end
  end

  // stage 3: drag factor
  logic               s3_valid;
  keep_t              s3_keep;
  logic               s3_flag;
  logic signed [31:0] s3_p [2];
  logic signed [31:0] s3_v [2];
  logic signed [31:0] s3_f [2];
  logic [45:0]        s3_k;
  logic signed [46:0] s3_g;
  logic [30:0]        s3_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_keep <= s2_keep;
    s3_flag <= s2_flag;
    s3_k    <= 46'((62'(s2_r2) * 62'(drag_coefficient) + 62'd32768) >> 16);
    s3_g    <= s2_g;
    s3_m    <= s2_m;
    for (int i = 0; i < 2; i++) begin
      s3_p[i] <= s2_p[i];
      s3_v[i] <= s2_v[i];
      s3_f[i] <= s2_f[i];
    end
  end

  // stage 4: v * k in two partial products
  logic               s4_valid;
  keep_t              s4_keep;
  logic               s4_flag;
  logic signed [31:0] s4_p [2];
  logic signed [31:0] s4_v [2];
  logic signed [31:0] s4_f [2];
  logic signed [55:0] s4_pkh [2];
  logic signed [55:0] s4_pkl [2];
  logic signed [46:0] s4_g;
  logic [30:0]        s4_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_keep <= s3_keep;
    s4_flag <= s3_flag;
    s4_g    <= s3_g;
    s4_m    <= s3_m;
    for (int i = 0; i < 2; i++) begin
      s4_pkh[i] <= 56'(s3_v[i]) * 56'($signed({1'b0, s3_k[45:23]}));
      s4_pkl[i] <= 56'(s3_v[i]) * 56'($signed({1'b0, s3_k[22:0]}));
      s4_p[i]   <= s3_p[i];
      s4_v[i]   <= s3_v[i];
      s4_f[i]   <= s3_f[i];
    end
  end

  // stage 5: combine partial products
  logic               s5_valid;
  keep_t              s5_keep;
  logic               s5_flag;
  logic signed [31:0] s5_p [2];
  logic signed [31:0] s5_v [2];
  logic signed [31:0] s5_f [2];
  logic signed [78:0] s5_d [2];
  logic signed [46:0] s5_g;
  logic [30:0]        s5_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
    s5_keep <= s4_keep;
    s5_flag <= s4_flag;
    s5_g    <= s4_g;
    s5_m    <= s4_m;
    for (int i = 0; i < 2; i++) begin
      s5_d[i] <= 79'((SW'(s4_pkh[i]) <<< 23) + SW'(s4_pkl[i]));
      s5_p[i] <= s4_p[i];
      s5_v[i] <= s4_v[i];
      s5_f[i] <= s4_f[i];
    end
  end

  // stage 6: drag term
  logic signed [31:0] s6_drag_next [2];
  logic               s6_flag_next;

  always_comb begin
    s6_flag_next = s5_flag;
    for (int i = 0; i < 2; i++) begin
      s6_drag_next[i] = sat_val(rnd_shr(-SW'(s5_d[i]), 16));
      s6_flag_next    = s6_flag_next | sat_ovf(rnd_shr(-SW'(s5_d[i]), 16));
    end
  end

  logic               s6_valid;
  keep_t              s6_keep;
  logic               s6_flag;
  logic signed [31:0] s6_p [2];
  logic signed [31:0] s6_v [2];
  logic signed [31:0] s6_f [2];
  logic signed [31:0] s6_drag [2];
  logic signed [46:0] s6_g;
  logic [30:0]        s6_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else begin
      s6_valid <= s5_valid;
    end
    s6_keep <= s5_keep;
    s6_flag <= s6_flag_next;
    s6_g    <= s5_g;
    s6_m    <= s5_m;
    for (int i = 0; i < 2; i++) begin
      s6_drag[i] <= s6_drag_next[i];
      s6_p[i]    <= s5_p[i];
      s6_v[i]    <= s5_v[i];
      s6_f[i]    <= s5_f[i];
    end
  end

  // stage 7: total force
  logic signed [SW-1:0] s7_sum [2];
  logic                 s7_flag_next;

  always_comb begin
    s7_sum[0]    = SW'(s6_f[0]) + SW'(s6_drag[0]);
    s7_sum[1]    = SW'(s6_f[1]) + SW'(s6_drag[1]) + SW'(s6_g);
    s7_flag_next = s6_flag | sat_ovf(s7_sum[0]) | sat_ovf(s7_sum[1]);
  end

  logic               s7_valid;
  keep_t              s7_keep;
  logic               s7_flag;
  logic signed [31:0] s7_p [2];
  logic signed [31:0] s7_v [2];
  logic signed [31:0] s7_f [2];
  logic [30:0]        s7_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else begin
      s7_valid <= s6_valid;
    end
    s7_keep <= s6_keep;
    s7_flag <= s7_flag_next;
    s7_m    <= s6_m;
    for (int i = 0; i < 2; i++) begin
      s7_f[i] <= sat_val(s7_sum[i]);
      s7_p[i] <= s6_p[i];
      s7_v[i] <= s6_v[i];
    end
  end

  // acceleration divide, with matching delay line for the rest of the word
  logic signed [DIV_NUM_BITS:0] quo [2];

  pwbi_div u_div_x (.clk(clk), .num(s7_f[0]), .den(s7_m), .quo(quo[0]));
  pwbi_div u_div_y (.clk(clk), .num(s7_f[1]), .den(s7_m), .quo(quo[1]));

  logic               dl_valid [DIV_LAT];
  keep_t              dl_keep  [DIV_LAT];
  logic               dl_flag  [DIV_LAT];
  logic signed [31:0] dl_p     [DIV_LAT][2];
  logic signed [31:0] dl_v     [DIV_LAT][2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < DIV_LAT; j++) begin
        dl_valid[j] <= 1'b0;
      end
    end else begin
      dl_valid[0] <= s7_valid;
      for (int j = 1; j < DIV_LAT; j++) begin
        dl_valid[j] <= dl_valid[j-1];
      end
    end
    dl_keep[0] <= s7_keep;
    dl_flag[0] <= s7_flag;
    for (int i = 0; i < 2; i++) begin
      dl_p[0][i] <= s7_p[i];
      dl_v[0][i] <= s7_v[i];
    end
    for (int j = 1; j < DIV_LAT; j++) begin
      dl_keep[j] <= dl_keep[j-1];
      dl_flag[j] <= dl_flag[j-1];
      for (int i = 0; i < 2; i++) begin
        dl_p[j][i] <= dl_p[j-1][i];
        dl_v[j][i] <= dl_v[j-1][i];
      end
    end
  end

  // stage 8: clip acceleration
  logic s8_flag_next;

  always_comb begin
    s8_flag_next = dl_flag[DIV_LAT-1] | sat_ovf(SW'(quo[0])) | sat_ovf(SW'(quo[1]));
  end

  logic               s8_valid;
  keep_t              s8_keep;
  logic               s8_flag;
  logic signed [31:0] s8_p [2];
  logic signed [31:0] s8_v [2];
  logic signed [31:0] s8_a [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
    end else begin
      s8_valid <= dl_valid[DIV_LAT-1];
    end
    s8_keep <= dl_keep[DIV_LAT-1];
    s8_flag <= s8_flag_next;
    for (int i = 0; i < 2; i++) begin
      s8_a[i] <= sat_val(SW'(quo[i]));
      s8_p[i] <= dl_p[DIV_LAT-1][i];
      s8_v[i] <= dl_v[DIV_LAT-1][i];
    end
  end

  // stage 9: a*dt and v*dt
  logic               s9_valid;
  keep_t              s9_keep;
  logic               s9_flag;
  logic signed [31:0] s9_p [2];
  logic signed [31:0] s9_v [2];
  logic signed [57:0] s9_ad [2];
  logic signed [57:0] s9_vdt [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_valid <= 1'b0;
    end else begin
      s9_valid <= s8_valid;
    end
    s9_keep <= s8_keep;
    s9_flag <= s8_flag;
    for (int i = 0; i < 2; i++) begin
      s9_ad[i]  <= 58'(s8_a[i]) * 58'(dt_s);
      s9_vdt[i] <= 58'(s8_v[i]) * 58'(dt_s);
      s9_p[i]   <= s8_p[i];
      s9_v[i]   <= s8_v[i];
    end
  end

  // stage 10: a*dt*dt split, velocity sum
  logic signed [33:0] s10_adh [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      s10_adh[i] = 34'(s9_ad[i] >>> 24);
    end
  end

  logic               s10_valid;
  keep_t              s10_keep;
  logic               s10_flag;
  logic signed [31:0] s10_p [2];
  logic signed [59:0] s10_hp [2];
  logic [48:0]        s10_lp [2];
  logic signed [33:0] s10_vterm [2];
  logic signed [35:0] s10_nv [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_valid <= 1'b0;
    end else begin
      s10_valid <= s9_valid;
    end
    s10_keep <= s9_keep;
    s10_flag <= s9_flag;
    for (int i = 0; i < 2; i++) begin
      s10_hp[i]    <= 60'(s10_adh[i]) * 60'(dt_s);
      s10_lp[i]    <= 49'(s9_ad[i][23:0]) * 49'(time_step);
      s10_vterm[i] <= 34'(rnd_shr(SW'(s9_vdt[i]), 24));
      s10_nv[i]    <= 36'(SW'(s9_v[i]) + rnd_shr(SW'(s9_ad[i]), 24));
      s10_p[i]     <= s9_p[i];
    end
  end

  // stage 11: position sum
  logic signed [SW-1:0] s11_half [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      s11_half[i] = (SW'(s10_hp[i]) + $signed(SW'(s10_lp[i] >> 24)) + (ONE_S <<< 24)) >>> 25;
    end
  end

  logic               s11_valid;
  keep_t              s11_keep;
  logic               s11_flag;
  logic signed [39:0] s11_np [2];
  logic signed [35:0] s11_nv [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      s11_valid <= 1'b0;
    end else begin
      s11_valid <= s10_valid;
    end
    s11_keep <= s10_keep;
    s11_flag <= s10_flag;
    for (int i = 0; i < 2; i++) begin
      s11_np[i] <= 40'(SW'(s10_p[i]) + SW'(s10_vterm[i]) + s11_half[i]);
      s11_nv[i] <= s10_nv[i];
    end
  end

  // output register
  logic sat_next;

  always_comb begin
    sat_next = s11_flag | sat_ovf(SW'(s11_np[0])) | sat_ovf(SW'(s11_np[1]))
             | sat_ovf(SW'(s11_nv[0])) | sat_ovf(SW'(s11_nv[1]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s11_valid;
    end
    mass_error <= s11_keep.err;
    saturated  <= !s11_keep.bypass && sat_next;
    if (s11_keep.bypass) begin
      new_pos_x <= s11_keep.p_x;
      new_pos_y <= s11_keep.p_y;
      new_vel_x <= s11_keep.v_x;
      new_vel_y <= s11_keep.v_y;
    end else begin
      new_pos_x <= sat_val(SW'(s11_np[0]));
      new_pos_y <= sat_val(SW'(s11_np[1]));
      new_vel_x <= sat_val(SW'(s11_nv[0]));
      new_vel_y <= sat_val(SW'(s11_nv[1]));
    end
  end

endmodule

// ===== tb/pwbi_checker.sv =====
// Checker for the wall bounce integrator: watches words in and out, predicts and compares.
module pwbi_checker import pwbi_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [31:0]               cfg_data,
  input  logic signed [31:0]        pos_x,
  input  logic signed [31:0]        pos_y,
  input  logic signed [31:0]        vel_x,
  input  logic signed [31:0]        vel_y,
  input  logic signed [31:0]        force_x,
  input  logic signed [31:0]        force_y,
  input  logic [30:0]               radius,
  input  logic [30:0]               mass,
  input  logic                      is_fixed,
  input  logic                      is_collidable,
  input  logic                      done,
  input  logic signed [31:0]        new_pos_x,
  input  logic signed [31:0]        new_pos_y,
  input  logic signed [31:0]        new_vel_x,
  input  logic signed [31:0]        new_vel_y,
  input  logic                      mass_error,
  input  logic                      saturated,
  output int                        errors,
  output int                        pending
);

  localparam longint HI = 64'sd2147483647;
  localparam longint LO = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] p_x;
    logic signed [31:0] p_y;
    logic signed [31:0] v_x;
    logic signed [31:0] v_y;
    logic               err;
    logic               sat;
  } motion_t;

  logic [16:0]        restitution;
  logic [15:0]        drag_coef;
  logic signed [31:0] gravity;
  logic [30:0]        half_w;
  logic [30:0]        half_h;
  logic [24:0]        dt_reg;

  motion_t motion_q[$];

  function automatic longint clip(longint x, inout bit f);
    if (x > HI) begin
      f = 1;
      return HI;
    end
    if (x < LO) begin
      f = 1;
      return LO;
    end
    return x;
  endfunction

  function automatic longint rnd_shr(longint x, int n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic void wall_clamp(inout longint p, inout longint v, input longint half,
                                     input longint r, inout bit f);
    longint lo_b;
    longint hi_b;
    bit hit;
    lo_b = -half + r;
    hi_b = half - r;
    hit = 0;
    if (p < lo_b) begin
      p = clip(lo_b, f);
      hit = 1;
    end else if (p > hi_b) begin
      p = clip(hi_b, f);
      hit = 1;
    end
    if (hit) v = clip(rnd_shr(-v * longint'(restitution), 16), f);
  endfunction

  function automatic longint drag_force(longint v, longint k, inout bit f);
    longint mag;
    mag = (v < 0) ? -v : v;
    if (k > 0 && mag > (longint'(1) <<< 62) / k)
      return clip((v > 0) ? -(longint'(1) <<< 40) : (longint'(1) <<< 40), f);
    return clip(rnd_shr(-v * k, 16), f);
  endfunction

  function automatic void step_axis(inout longint p, inout longint v, input longint frc,
                                    input longint m, inout bit f);
    longint dt;
    longint acc;
    longint ad;
    longint adh;
    longint adl;
    longint half_term;
    longint np;
    longint nv;
    dt = longint'(dt_reg);
    acc = clip((frc * 65536) / m, f);
    ad = acc * dt;
    adh = ad >>> 24;
    adl = ad - adh * (longint'(1) <<< 24);
    half_term = (adh * dt + ((adl * dt) >>> 24) + (longint'(1) <<< 24)) >>> 25;
    np = p + rnd_shr(v * dt, 24) + half_term;
    nv = v + rnd_shr(ad, 24);
    p = clip(np, f);
    v = clip(nv, f);
  endfunction

  function automatic motion_t predict_motion();
    motion_t res;
    longint px, py, vx, vy, fx, fy, r, m, r2, k, g;
    bit f;
    px = pos_x;
    py = pos_y;
    vx = vel_x;
    vy = vel_y;
    fx = force_x;
    fy = force_y;
    r = longint'(radius);
    m = longint'(mass);
    f = 0;
    res.err = 0;
    if (!is_fixed && m == 0) begin
      res.err = 1;
    end else if (!is_fixed) begin
      if (is_collidable) begin
        wall_clamp(px, vx, longint'(half_w), r, f);
        wall_clamp(py, vy, longint'(half_h), r, f);
      end
      r2 = (r * r + 32768) >>> 16;
      k = (r2 * longint'(drag_coef) + 32768) >>> 16;
      g = rnd_shr(longint'(gravity) * m, 16);
      fx = clip(fx + drag_force(vx, k, f), f);
      fy = clip(fy + drag_force(vy, k, f) + g, f);
      step_axis(px, vx, fx, m, f);
      step_axis(py, vy, fy, m, f);
    end
    res.p_x = px[31:0];
    res.p_y = py[31:0];
    res.v_x = vx[31:0];
    res.v_y = vy[31:0];
    res.sat = f;
    return res;
  endfunction

  always @(posedge clk) begin
    motion_t exp_m;
    if (rst) begin
      restitution <= 17'd65536;
      drag_coef   <= 16'd6554;
      gravity     <= -32'sd642908;
      half_w      <= 31'd7824998;
      half_h      <= 31'd5203558;
      dt_reg      <= 25'd17476;
      motion_q.delete();
      pending     <= 0;
      errors      = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_RESTITUTION:      restitution <= cfg_data[16:0];
          REG_DRAG_COEFFICIENT: drag_coef   <= cfg_data[15:0];
          REG_GRAVITY_Y:        gravity     <= cfg_data;
          REG_WALL_HALF_WIDTH:  half_w      <= cfg_data[30:0];
          REG_WALL_HALF_HEIGHT: half_h      <= cfg_data[30:0];
          REG_TIME_STEP:        dt_reg      <= cfg_data[24:0];
          default: ;
        endcase
      end
      if (done) begin
        if (motion_q.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          exp_m = motion_q.pop_front();
          if (new_pos_x !== exp_m.p_x) begin
            $error("new_pos_x expected %0d actual %0d", exp_m.p_x, new_pos_x);
            errors++;
          end
          if (new_pos_y !== exp_m.p_y) begin
            $error("new_pos_y expected %0d actual %0d", exp_m.p_y, new_pos_y);
            errors++;
          end
          if (new_vel_x !== exp_m.v_x) begin
            $error("new_vel_x expected %0d actual %0d", exp_m.v_x, new_vel_x);
            errors++;
          end
          if (new_vel_y !== exp_m.v_y) begin
            $error("new_vel_y expected %0d actual %0d", exp_m.v_y, new_vel_y);
            errors++;
          end
          if (mass_error !== exp_m.err) begin
            $error("mass_error expected %0b actual %0b", exp_m.err, mass_error);
            errors++;
          end
          if (saturated !== exp_m.sat) begin
            $error("saturated expected %0b actual %0b", exp_m.sat, saturated);
            errors++;
          end
        end
      end
      if (start && !busy) motion_q = {motion_q, predict_motion()};
      pending <= motion_q.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the wall bounce integrator testbench: clock, reset, stimulus and verdict.
module tb_top import pwbi_pkg::*;;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [31:0]               cfg_data;
  logic signed [31:0]        pos_x, pos_y, vel_x, vel_y, force_x, force_y;
  logic [30:0]               radius, mass;
  logic                      is_fixed, is_collidable;
  logic                      done;
  logic signed [31:0]        new_pos_x, new_pos_y, new_vel_x, new_vel_y;
  logic                      mass_error, saturated;
  int                        errors;
  int                        pending;

  particle_wall_bounce_integrator dut (.*);
  pwbi_checker chk (.*);

  always #5 clk = ~clk;

  initial begin
    #50_000_000;
    $display("FAIL particle_wall_bounce_integrator");
    $finish;
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3, 4: return $urandom;
      default: return $urandom_range(0, 32'h1ffffff) - 32'h1000000;
    endcase
  endfunction

  function automatic logic [30:0] pick_size(bit allow_zero);
    case ($urandom_range(0, 9))
      0: return allow_zero ? 31'd0 : 31'd1;
      1: return 31'h7fffffff;
      2: return 31'd1;
      3: return 31'($urandom >> 1);
      default: return 31'($urandom_range(1, 32'h200000));
    endcase
  endfunction

  task automatic send(logic [31:0] px, logic [31:0] py, logic [31:0] vx, logic [31:0] vy,
                      logic [31:0] fx, logic [31:0] fy, logic [30:0] r, logic [30:0] m,
                      logic fixd, logic coll);
    start         <= 1'b1;
    pos_x         <= px;
    pos_y         <= py;
    vel_x         <= vx;
    vel_y         <= vy;
    force_x       <= fx;
    force_y       <= fy;
    radius        <= r;
    mass          <= m;
    is_fixed      <= fixd;
    is_collidable <= coll;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_random();
    send(pick_word(), pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
         pick_size(1), pick_size($urandom_range(0, 15) == 0), $urandom_range(0, 9) == 0,
         $urandom_range(0, 3) != 0);
  endtask

  task automatic drain();
    int guard;
    start <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (pending != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (70) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] rest, logic [31:0] drag, logic [31:0] grav,
                            logic [31:0] hw, logic [31:0] hh, logic [31:0] dt);
    write_reg(REG_RESTITUTION, rest);
    write_reg(REG_DRAG_COEFFICIENT, drag);
    write_reg(REG_GRAVITY_Y, grav);
    write_reg(REG_WALL_HALF_WIDTH, hw);
    write_reg(REG_WALL_HALF_HEIGHT, hh);
    write_reg(REG_TIME_STEP, dt);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_burst_run(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        send_random();
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  initial begin
    clk = 0;
    rst = 1;
    start = 0;
    cfg_write = 0;
    cfg_index = '0;
    cfg_data = '0;
    pos_x = 0; pos_y = 0; vel_x = 0; vel_y = 0; force_x = 0; force_y = 0;
    radius = 0; mass = 0; is_fixed = 0; is_collidable = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words under reset configuration
    send(32'd100, 32'd200, 32'd65536, -32'd65536, 32'd0, 32'd0, 31'd65536, 31'd0, 0, 1);
    send(32'd100, 32'd200, 32'd65536, -32'd65536, 32'd0, 32'd0, 31'd65536, 31'd0, 1, 1);
    send(32'h12345678, -32'd5, 32'd7, 32'd9, 32'd11, 32'd13, 31'd65536, 31'd65536, 1, 0);
    send(-32'd9000000, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd0, 31'd65536, 31'd65536, 0, 1);
    send(32'd9000000, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd0, 31'd65536, 31'd65536, 0, 1);
    send(32'd0, -32'd6000000, 32'd0, -32'd131072, 0, 0, 31'd65536, 31'd65536, 0, 1);
    send(32'd0, 32'd6000000, 32'd0, 32'd131072, 0, 0, 31'd65536, 31'd65536, 0, 1);
    send(-32'd9000000, 32'd6000000, 32'd65536, 32'd0, 0, 0, 31'd65536, 31'd65536, 0, 0);
    send(32'd0, 32'd0, 32'd0, 32'd0, 0, 0, 31'd20000000, 31'd65536, 0, 1);
    send(32'd5, 32'd5, 32'd0, 32'd0, 0, 0, 31'h7fffffff, 31'd65536, 0, 1);
    send(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
         32'h80000000, 31'h7fffffff, 31'h7fffffff, 0, 1);
    send(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
         32'h7fffffff, 31'd1, 31'd1, 0, 0);
    send(32'd0, 32'd0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
         31'd0, 31'd1, 0, 1);
    send(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 31'd0, 31'h7fffffff, 0, 0);
    drain();

    random_burst_run(100);
    drain();
    set_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1);
    random_burst_run(100);
    drain();
    set_config(32'd65536, 32'd32768, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'd16777216);
    random_burst_run(100);
    drain();
    set_config(32'd131071, 32'd65535, 32'h80000000, $urandom >> 1, $urandom >> 1,
               32'h1ffffff);
    random_burst_run(100);
    drain();
    set_config(32'd32768, 32'd6554, -32'd642908, 32'd7824998, 32'd5203558, 32'd0);
    random_burst_run(100);
    drain();
    set_config($urandom_range(0, 65536), $urandom_range(0, 32768), $urandom,
               $urandom >> 8, $urandom >> 8, $urandom_range(1, 16777216));
    random_burst_run(100);
    drain();
    set_config(32'd65536, 32'd6554, -32'd642908, 32'd7824998, 32'd5203558, 32'd17476);
    random_burst_run(100);
    drain();

    if (errors == 0 && pending == 0) begin
      $display("PASS particle_wall_bounce_integrator");
    end else begin
      $display("FAIL particle_wall_bounce_integrator");
    end
    $finish;
  end

endmodule
